@@ sv/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int CP_W  = 21;
	localparam int ORD_W = 12;

	localparam int MAX_ORDINAL = 4095;
	localparam logic [ORD_W-1:0] ORD_LIMIT =
		(MAX_ORDINAL > 4095) ? ORD_W'(4095) : ORD_W'(MAX_ORDINAL);

	localparam logic [CP_W-1:0] REPL_CP = CP_W'(21'h00FFFD);

	// Results caused by one input byte: rep_cnt replacement characters first,
	// then optionally one tail result.
	typedef struct packed {
		logic [1:0]      rep_cnt;
		logic            tail;
		logic [CP_W-1:0] tail_cp;
		logic            tail_repl;
		logic            fin;
	} burst_t;

endpackage

@@ sv/utf8d_decode.sv @@
// Byte classifier and sequence state: turns each accepted byte into a result burst.
`timescale 1ns / 1ps

module utf8d_decode (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              text_byte,
	input  logic                    final_byte,
	output utf8d_pkg::burst_t       burst
);

	logic [1:0]                 need_q;
	logic [1:0]                 taken_q;
	logic [utf8d_pkg::CP_W-1:0] partial_q;

	logic [1:0]                 need_d;
	logic [1:0]                 taken_d;
	logic [utf8d_pkg::CP_W-1:0] partial_d;

	logic                       is_cont;
	logic [1:0]                 taken_inc;
	logic [utf8d_pkg::CP_W-1:0] code_inc;
	logic                       fresh_ascii;
	logic [1:0]                 fresh_need;
	logic [utf8d_pkg::CP_W-1:0] fresh_code;

	assign is_cont   = (text_byte[7:6] == 2'b10);
	assign taken_inc = taken_q + 2'd1;
	assign code_inc  = {partial_q[utf8d_pkg::CP_W-7:0], text_byte[5:0]};

	always_comb begin
		fresh_ascii = 1'b0;
		fresh_need  = 2'd0;
		fresh_code  = '0;
		if (text_byte inside {[8'h00:8'h7F]}) begin
			fresh_ascii = 1'b1;
		end else if (text_byte inside {[8'hC0:8'hDF]}) begin
			fresh_need = 2'd1;
			fresh_code = {16'd0, text_byte[4:0]};
		end else if (text_byte inside {[8'hE0:8'hEF]}) begin
			fresh_need = 2'd2;
			fresh_code = {17'd0, text_byte[3:0]};
		end else if (text_byte inside {[8'hF0:8'hF7]}) begin
			fresh_need = 2'd3;
			fresh_code = {18'd0, text_byte[2:0]};
		end
	end

	always_comb begin
		burst           = '0;
		burst.fin       = final_byte;
		need_d          = need_q;
		taken_d         = taken_q;
		partial_d       = partial_q;
		if (need_q != 2'd0 && is_cont) begin
			if (taken_inc >= need_q) begin
				burst.tail    = 1'b1;
				burst.tail_cp = code_inc;
				need_d        = 2'd0;
				taken_d       = 2'd0;
				partial_d     = '0;
			end else if (final_byte) begin
				// Lead plus every continuation taken, this one included.
				burst.rep_cnt = taken_inc + 2'd1;
			end else begin
				taken_d   = taken_inc;
				partial_d = code_inc;
			end
		end else begin
			if (need_q != 2'd0) begin
				// Broken sequence: replace what was taken, then handle this byte afresh.
				burst.rep_cnt = taken_q + 2'd1;
				need_d        = 2'd0;
				taken_d       = 2'd0;
				partial_d     = '0;
			end
			if (fresh_ascii) begin
				burst.tail    = 1'b1;
				burst.tail_cp = {13'd0, text_byte};
			end else if (fresh_need != 2'd0 && !final_byte) begin
				need_d    = fresh_need;
				taken_d   = 2'd0;
				partial_d = fresh_code;
			end else begin
				burst.tail      = 1'b1;
				burst.tail_cp   = utf8d_pkg::REPL_CP;
				burst.tail_repl = 1'b1;
			end
		end
		if (final_byte) begin
			need_d    = 2'd0;
			taken_d   = 2'd0;
			partial_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q    <= 2'd0;
			taken_q   <= 2'd0;
			partial_q <= '0;
		end else if (accept) begin
			need_q    <= need_d;
			taken_q   <= taken_d;
			partial_q <= partial_d;
		end
	end

endmodule

@@ sv/utf8d_emit.sv @@
// Burst register and result register: sends a burst out one result per beat.
`timescale 1ns / 1ps

module utf8d_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  utf8d_pkg::burst_t           burst,
	output logic                        ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [utf8d_pkg::CP_W-1:0]  code_point,
	output logic                        replaced,
	output logic [utf8d_pkg::ORD_W-1:0] ordinal,
	output logic                        text_done
);

	logic [1:0]                  rep_s1;
	logic                        tail_s1;
	logic [utf8d_pkg::CP_W-1:0]  tail_cp_s1;
	logic                        tail_repl_s1;
	logic                        fin_s1;

	logic                        out_valid_q;
	logic [utf8d_pkg::CP_W-1:0]  cp_q;
	logic                        repl_q;
	logic [utf8d_pkg::ORD_W-1:0] ord_out_q;
	logic                        done_q;
	logic [utf8d_pkg::ORD_W-1:0] ord_q;

	logic busy;
	logic out_free;
	logic emit;
	logic last;

	assign busy     = (rep_s1 != 2'd0) || tail_s1;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = busy && out_free;
	assign last     = (rep_s1 == 2'd0) || (rep_s1 == 2'd1 && !tail_s1);
	assign ready    = !busy || (emit && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_s1  <= 2'd0;
			tail_s1 <= 1'b0;
			fin_s1  <= 1'b0;
		end else if (load) begin
			rep_s1  <= burst.rep_cnt;
			tail_s1 <= burst.tail;
			fin_s1  <= burst.fin;
		end else if (emit) begin
			if (rep_s1 != 2'd0) begin
				rep_s1 <= rep_s1 - 2'd1;
			end else begin
				tail_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tail_cp_s1   <= burst.tail_cp;
			tail_repl_s1 <= burst.tail_repl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ord_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				// The ordinal restarts after the last result of a text.
				if (last && fin_s1) begin
					ord_q <= '0;
				end else if (ord_q < utf8d_pkg::ORD_LIMIT) begin
					ord_q <= ord_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ord_out_q <= ord_q;
			done_q    <= last && fin_s1;
			if (rep_s1 != 2'd0) begin
				cp_q   <= utf8d_pkg::REPL_CP;
				repl_q <= 1'b1;
			end else begin
				cp_q   <= tail_cp_s1;
				repl_q <= tail_repl_s1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign replaced   = repl_q;
	assign ordinal    = ord_out_q;
	assign text_done  = done_q;

endmodule

@@ sv/utf8_stream_decoder.sv @@
// Streaming UTF-8 decoder: one text byte in per beat, code points out per beat.
// Bursts are held in the burst register, results in the output register.
// Throughput: one byte per cycle if the output is free; a byte with several results
// (up to four, on a broken sequence) holds the input while the burst register drains.
// Reset: asynchronous, active low; clears pending sequence, ordinal count and valids.
`timescale 1ns / 1ps

module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [20:0] code_point, [32:21] ordinal, [39:33] zero
	output logic        m_tuser,   // replaced
	output logic        m_tlast    // text_done
);

	utf8d_pkg::burst_t           burst;
	logic                        accept;
	logic [utf8d_pkg::CP_W-1:0]  code_point;
	logic [utf8d_pkg::ORD_W-1:0] ordinal;

	assign accept = s_tvalid && s_tready;

	utf8d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.text_byte  (s_tdata),
		.final_byte (s_tlast),
		.burst      (burst)
	);

	utf8d_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.burst      (burst),
		.ready      (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.code_point (code_point),
		.replaced   (m_tuser),
		.ordinal    (ordinal),
		.text_done  (m_tlast)
	);

	assign m_tdata = {7'd0, ordinal, code_point};

endmodule

@@ bench/utf8_stream_decoder_tb.sv @@
// Self-checking testbench for the UTF-8 stream decoder with a built-in code point predictor.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

	typedef struct {
		logic [7:0] text_byte;
		bit         final_byte;
	} text_beat_t;

	typedef struct {
		logic [utf8d_pkg::CP_W-1:0]  code_point;
		bit                          replaced;
		logic [utf8d_pkg::ORD_W-1:0] ordinal;
		bit                          text_done;
	} code_point_t;

	localparam int RANDOM_BEATS = 254;
	localparam int HOLD_CYCLES  = 300;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	text_beat_t  pending_beats[$];
	code_point_t expected_points[$];

	// Predictor state: the sequence being gathered and the count within the text.
	logic [1:0]                  seq_need   = '0;
	logic [1:0]                  seq_taken  = '0;
	logic [utf8d_pkg::CP_W-1:0]  seq_code   = '0;
	logic [utf8d_pkg::ORD_W-1:0] text_count = '0;

	int   err_count = 0;
	int   in_beats  = 0;
	bit   in_fire   = 1'b0;
	bit   out_fire  = 1'b0;
	int   tx_wait   = 0;
	int   rx_wait   = 0;
	bit   tx_calm   = 1'b0;
	bit   rx_calm   = 1'b0;
	logic hold_rx   = 1'b0;

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, and stretches where the side never idles.
	function automatic int idle_len(inout bit calm);
		int r;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		err_count++;
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic void emit_point(logic [utf8d_pkg::CP_W-1:0] cp, bit repl);
		code_point_t p;
		p.code_point = cp;
		p.replaced   = repl;
		p.ordinal    = text_count;
		p.text_done  = 1'b0;
		expected_points.push_back(p);
		if (text_count < utf8d_pkg::ORD_LIMIT)
			text_count++;
	endfunction

	function automatic void emit_replacements(int count);
		for (int i = 0; i < count; i++)
			emit_point(utf8d_pkg::REPL_CP, 1'b1);
	endfunction

	function automatic void clear_sequence();
		seq_need  = '0;
		seq_taken = '0;
		seq_code  = '0;
	endfunction

	function automatic void start_fresh(logic [7:0] b, bit fin);
		logic [1:0]                 need;
		logic [utf8d_pkg::CP_W-1:0] code;
		need = '0;
		code = '0;
		if (b < 8'h80) begin
			emit_point(utf8d_pkg::CP_W'(b), 1'b0);
			return;
		end
		if (b[7:5] == 3'b110) begin
			code = utf8d_pkg::CP_W'(b[4:0]);
			need = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			code = utf8d_pkg::CP_W'(b[3:0]);
			need = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			code = utf8d_pkg::CP_W'(b[2:0]);
			need = 2'd3;
		end
		if (need == 0 || fin)
			emit_point(utf8d_pkg::REPL_CP, 1'b1);
		else begin
			seq_need  = need;
			seq_taken = '0;
			seq_code  = code;
		end
	endfunction

	function automatic void predict_beat(logic [7:0] b, bit fin);
		int                         prior;
		int                         taken;
		logic [utf8d_pkg::CP_W-1:0] code;
		prior = expected_points.size();
		if (seq_need != 0) begin
			if (b[7:6] == 2'b10) begin
				taken = int'(seq_taken) + 1;
				code  = {seq_code[utf8d_pkg::CP_W-7:0], b[5:0]};
				if (taken >= int'(seq_need)) begin
					emit_point(code, 1'b0);
					clear_sequence();
				end else if (fin) begin
					emit_replacements(taken + 1);
					clear_sequence();
				end else begin
					seq_taken = 2'(taken);
					seq_code  = code;
				end
			end else begin
				// The lead and each continuation taken so far are replaced, then
				// the breaking byte starts over.
				emit_replacements(int'(seq_taken) + 1);
				clear_sequence();
				start_fresh(b, fin);
			end
		end else
			start_fresh(b, fin);
		if (fin) begin
			if (expected_points.size() > prior)
				expected_points[expected_points.size()-1].text_done = 1'b1;
			clear_sequence();
			text_count = '0;
		end
	endfunction

	task automatic queue_beat(logic [7:0] b, bit fin);
		text_beat_t t;
		t.text_byte  = b;
		t.final_byte = fin;
		pending_beats.push_back(t);
	endtask

	task automatic queue_text(logic [7:0] text[$]);
		foreach (text[i])
			queue_beat(text[i], i == text.size() - 1);
	endtask

	function automatic logic [7:0] lead_byte(int len);
		case (len)
			2:       return {3'b110, 5'($urandom)};
			3:       return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// One unit of text: mostly well-formed characters, the rest broken or stray bytes.
	task automatic queue_unit(bit fin);
		int         kind;
		int         len;
		int         conts;
		logic [7:0] brk;
		kind  = $urandom_range(0, 99);
		len   = $urandom_range(2, 4);
		conts = $urandom_range(0, len - 2);
		if (kind < 30)
			queue_beat(8'($urandom_range(0, 127)), fin);
		else if (kind < 70) begin
			queue_beat(lead_byte(len), 1'b0);
			for (int i = 1; i < len; i++)
				queue_beat(cont_byte(), fin && i == len - 1);
		end else if (kind < 82) begin
			queue_beat(lead_byte(len), 1'b0);
			for (int i = 0; i < conts; i++)
				queue_beat(cont_byte(), 1'b0);
			brk = 8'($urandom);
			while (brk[7:6] == 2'b10)
				brk = 8'($urandom);
			queue_beat(brk, fin);
		end else if (kind < 88) begin
			queue_beat(lead_byte(len), fin && conts == 0);
			for (int i = 1; i <= conts; i++)
				queue_beat(cont_byte(), fin && i == conts);
		end else if (kind < 94)
			queue_beat(cont_byte(), fin);
		else if (kind < 97)
			queue_beat(8'($urandom_range(248, 255)), fin);
		else
			queue_beat(8'($urandom), fin);
	endtask

	// Beats are offered at the falling edge and held until the block takes them.
	always @(negedge clk) begin
		if (!arst_n)
			s_tvalid <= 1'b0;
		else if (!s_tvalid || in_fire) begin
			if (tx_wait > 0) begin
				tx_wait--;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				s_tdata  <= pending_beats[0].text_byte;
				s_tlast  <= pending_beats[0].final_byte;
				s_tvalid <= 1'b1;
				pending_beats.pop_front();
				tx_wait = idle_len(tx_calm);
			end else
				s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (out_fire)
			rx_wait = idle_len(rx_calm);
		if (hold_rx || rx_wait > 0) begin
			m_tready <= 1'b0;
			if (rx_wait > 0)
				rx_wait--;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		code_point_t want;
		in_fire  = 1'b0;
		out_fire = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				in_fire = 1'b1;
				in_beats++;
				predict_beat(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				out_fire = 1'b1;
				if (expected_points.size() == 0)
					report_mismatch("result with nothing expected", m_tdata, 0);
				else begin
					want = expected_points.pop_front();
					if (m_tdata[20:0] !== want.code_point)
						report_mismatch("code_point", m_tdata[20:0], want.code_point);
					if (m_tdata[32:21] !== want.ordinal)
						report_mismatch("ordinal", m_tdata[32:21], want.ordinal);
					if (m_tdata[39:33] !== 7'd0)
						report_mismatch("tdata padding", m_tdata[39:33], 0);
					if (m_tuser !== want.replaced)
						report_mismatch("replaced", m_tuser, want.replaced);
					if (m_tlast !== want.text_done)
						report_mismatch("text_done", m_tlast, want.text_done);
				end
			end
		end
	end

	// The receiver holds off for a long stretch so the block backs up into its input.
	initial begin
		while (in_beats < 60)
			@(negedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		int base;
		int units;
		queue_text('{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF7, 8'hBF, 8'hBF, 8'hBF});
		queue_text('{8'h80, 8'hFF, 8'hF8, 8'hF0, 8'h9F, 8'h98, 8'h41, 8'hE2, 8'h82});
		queue_text('{8'hC3});
		queue_text('{8'hE2, 8'hC3, 8'hA9, 8'hC2, 8'h41});
		base = pending_beats.size();
		while (pending_beats.size() < base + RANDOM_BEATS) begin
			units = $urandom_range(1, 12);
			for (int u = 0; u < units; u++)
				queue_unit(u == units - 1);
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		while (pending_beats.size() != 0 || s_tvalid)
			@(negedge clk);
		while (expected_points.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (err_count == 0)
			$display("utf8_stream_decoder test passed");
		else
			$display("utf8_stream_decoder test failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("utf8_stream_decoder test failed");
		$finish;
	end

endmodule
